[sv/rrr_pkg.sv]
// Package for the round-robin ready ring: sizes, command and status codes,
// the scan token and the table write bus shared by the cells and the top level.
// No dependencies.
`default_nettype none

package rrr_pkg;

   localparam int TASK_COUNT = 16;
   localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int TASK_W     = 4;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REM  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NOT_QUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] STS_DUPLICATE  = 2'd2;

   // token walking down the cell row, picking up table reads on the way
   typedef struct packed {
      logic             live;
      logic [IDX_W-1:0] t;       // task being added or removed
      logic [IDX_W-1:0] lst;     // last-served task
      logic             t_in;    // task t is queued
      logic [IDX_W-1:0] t_succ;  // successor of t
      logic [IDX_W-1:0] l_succ;  // successor of last-served task
   } tok_type;

   // broadcast table update, applied by every cell in the same cycle
   typedef struct packed {
      logic             add;
      logic             rem;
      logic [IDX_W-1:0] t;
      logic             lst_ok;
      logic [IDX_W-1:0] lst;
      logic [IDX_W-1:0] data;
   } wr_type;

   function automatic logic [IDX_W-1:0] to_idx(input logic [TASK_W-1:0] tid);
      logic [IDX_W+TASK_W-1:0] w;
      begin
         w = {{IDX_W{1'b0}}, tid};
         return w[IDX_W-1:0];
      end
   endfunction

   function automatic logic [TASK_W-1:0] to_task(input logic [IDX_W-1:0] idx);
      logic [IDX_W+TASK_W-1:0] w;
      begin
         w = {{TASK_W{1'b0}}, idx};
         return w[TASK_W-1:0];
      end
   endfunction

   function automatic logic tid_in_range(input logic [TASK_W-1:0] tid);
      int unsigned v;
      begin
         v = 32'(tid);
         return v < TASK_COUNT;
      end
   endfunction

endpackage

`default_nettype wire

[sv/rrr_cell.sv]
// One ring table entry: queued flag and successor of a single task.
// Passes the scan token on each cycle and applies broadcast writes.
// Depends on rrr_pkg.
`default_nettype none

module rrr_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [rrr_pkg::IDX_W-1:0]    cell_idx,
   input  rrr_pkg::tok_type             tok_i,
   output rrr_pkg::tok_type             tok_o,
   input  rrr_pkg::wr_type              wr_i,
   output logic                         valid_o
);

   logic                      valid_ff, valid_in;
   logic [rrr_pkg::IDX_W-1:0] succ_ff, succ_in;
   rrr_pkg::tok_type          tok_ff, tok_in;

   always_comb begin
      tok_in = tok_i;
      if (tok_i.t == cell_idx) begin
         tok_in.t_in   = valid_ff;
         tok_in.t_succ = succ_ff;
      end
      if (tok_i.lst == cell_idx) begin
         tok_in.l_succ = succ_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      succ_in  = succ_ff;
      if (wr_i.add) begin
         if (cell_idx == wr_i.t) begin
            valid_in = 1'b1;
            succ_in  = wr_i.lst_ok ? wr_i.data : wr_i.t;
         end else if (wr_i.lst_ok && cell_idx == wr_i.lst) begin
            succ_in = wr_i.t;
         end
      end
      if (wr_i.rem) begin
         if (cell_idx == wr_i.t) begin
            valid_in = 1'b0;
         end else if (valid_ff && succ_ff == wr_i.t) begin
            // predecessor skips over the removed task
            succ_in = wr_i.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      succ_ff <= succ_in;
   end

   assign tok_o   = tok_ff;
   assign valid_o = valid_ff;

endmodule

`default_nettype wire

[sv/round_robin_ready_ring.sv]
// Round-robin ready ring: a row of TASK_COUNT cells holds the successor table.
// Each command sends a token down the row (one cell per cycle) to collect reads,
// then the update is broadcast to all cells in the same cycle and rsp_tvalid
// rises. One command in flight: req_tready stays low until the last command has
// committed; a result not yet taken delays the commit. Synchronous reset empties
// the ring at once; no clearing pass.
`default_nettype none

module round_robin_ready_ring (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [rrr_pkg::REQ_DATA_W-1:0]     req_tdata,  // [3:0] task_id, [7:4] zero
   input  wire  [rrr_pkg::CMD_W-1:0]          req_tuser,  // [1:0] command
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [rrr_pkg::RSP_DATA_W-1:0]     rsp_tdata   // [3:0] chosen_task,
                                                          // [4] chosen_valid,
                                                          // [6:5] status, [7] zero
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [rrr_pkg::CMD_W-1:0]     cmd_ff;
   logic [rrr_pkg::TASK_W-1:0]    tid_ff;
   logic [rrr_pkg::IDX_W-1:0]     last_ff, last_in;
   logic                          last_ok_ff, last_ok_in;
   rrr_pkg::tok_type              launch_ff, launch_in;
   rrr_pkg::tok_type              fin_ff;
   logic                          rsp_valid_ff;
   logic [rrr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   rrr_pkg::tok_type              tok_chain [rrr_pkg::TASK_COUNT+1];
   logic [rrr_pkg::TASK_COUNT-1:0] valid_vec;
   logic [rrr_pkg::TASK_COUNT-1:0] live_vec;
   rrr_pkg::wr_type               wr_c, wr_bus;

   logic                          req_xfer, commit, tid_ok;
   logic [rrr_pkg::STATUS_W-1:0]  status;
   logic [rrr_pkg::TASK_W-1:0]    chosen;
   logic                          cvalid;
   rrr_pkg::tok_type              tok_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign tok_end    = tok_chain[rrr_pkg::TASK_COUNT];
   assign commit     = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   assign tok_chain[0] = launch_ff;

   for (genvar k = 0; k < rrr_pkg::TASK_COUNT; k++) begin : g_cell
      rrr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (rrr_pkg::IDX_W'(k)),
         .tok_i    (tok_chain[k]),
         .tok_o    (tok_chain[k+1]),
         .wr_i     (wr_bus),
         .valid_o  (valid_vec[k])
      );
      assign live_vec[k] = tok_chain[k+1].live;
   end

   always_comb begin
      launch_in      = launch_ff;
      launch_in.live = 1'b0;
      if (req_xfer) begin
         launch_in.live   = 1'b1;
         launch_in.t      = rrr_pkg::to_idx(req_tdata[rrr_pkg::TASK_W-1:0]);
         launch_in.lst    = last_ff;
         launch_in.t_in   = 1'b0;
         launch_in.t_succ = '0;
         launch_in.l_succ = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tok_end.live) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // decide the outcome from the collected reads
   always_comb begin
      tid_ok     = rrr_pkg::tid_in_range(tid_ff);
      wr_c       = '0;
      wr_c.t     = fin_ff.t;
      wr_c.lst   = last_ff;
      wr_c.lst_ok = last_ok_ff;
      status     = rrr_pkg::STS_OK;
      chosen     = '0;
      cvalid     = 1'b0;
      last_in    = last_ff;
      last_ok_in = last_ok_ff;
      case (cmd_ff)
         rrr_pkg::CMD_ADD: begin
            if (!tid_ok) begin
               status = rrr_pkg::STS_NOT_QUEUED;
            end else if (fin_ff.t_in) begin
               status = rrr_pkg::STS_DUPLICATE;
            end else begin
               wr_c.add   = 1'b1;
               wr_c.data  = fin_ff.l_succ;
               last_in    = fin_ff.t;
               last_ok_in = 1'b1;
            end
         end
         rrr_pkg::CMD_REM: begin
            if (!tid_ok || !fin_ff.t_in) begin
               status = rrr_pkg::STS_NOT_QUEUED;
            end else begin
               wr_c.rem  = 1'b1;
               wr_c.data = fin_ff.t_succ;
               if (fin_ff.t_succ == fin_ff.t) begin
                  // sole member: ring empties
                  last_ok_in = 1'b0;
                  last_in    = '0;
               end else if (last_ok_ff && last_ff == fin_ff.t) begin
                  last_in = fin_ff.t_succ;
               end
            end
         end
         rrr_pkg::CMD_NEXT: begin
            if (last_ok_ff) begin
               last_in = fin_ff.l_succ;
               chosen  = rrr_pkg::to_task(fin_ff.l_succ);
               cvalid  = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in = {1'b0, status, cvalid, chosen};
   end

   assign wr_bus = commit ? wr_c : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_ff        <= '0;
         last_ok_ff     <= 1'b0;
         launch_ff.live <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         if (commit) begin
            last_ff      <= last_in;
            last_ok_ff   <= last_ok_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= req_tuser;
         tid_ff <= req_tdata[rrr_pkg::TASK_W-1:0];
      end
      if (state_ff == ST_SCAN && tok_end.live) begin
         fin_ff <= tok_end;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // at most one scan token in the cell row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(live_vec) <= 1)
      else $error("more than one scan token in the cell row");

   // a token only leaves the row while a scan is pending
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_end.live |-> state_ff == ST_SCAN)
      else $error("scan token arrived outside a scan");

   // a valid last-served pointer always names a queued task
   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      last_ok_ff |-> valid_vec[last_ff])
      else $error("last-served task is not queued");

   // a selected task comes only with ok status, and only with a live pointer
   a_chosen_ok: assert property (@(posedge clock) disable iff (reset)
      commit && cvalid |=> last_ok_ff && rsp_tdata[6:5] == rrr_pkg::STS_OK)
      else $error("selected task without ok status");

endmodule

`default_nettype wire
